@@ sv/assert_macros.svh @@
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond implies chk in the same cycle
`define ASSERT_SAME(lbl, cond, chk) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (chk)) \
    else $error("%m: check failed");

// cond implies chk in the next cycle
`define ASSERT_NEXT(lbl, cond, chk) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) \
    else $error("%m: check failed");

`endif

@@ sv/eocf_pkg.sv @@
`timescale 1ns / 1ps

package eocf_pkg;

  localparam logic [63:0] FNV_OFFSET      = 64'hcbf2_9ce4_8422_2325;
  // prime = 2^40 + 0x1b3
  localparam int          FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;
  localparam logic [7:0]  BYTE_MASK       = 8'hff;
  localparam logic [63:0] TS_MIN          = 64'h8000_0000_0000_0000;

  localparam int MSG_W      = 256;   // four fields, 8 bytes each
  localparam int WORD_W     = 32;    // bytes mixed per cycle * 8
  localparam int HASH_STEPS = MSG_W / WORD_W;
  localparam int STEP_CNT_W = $clog2(HASH_STEPS);

  typedef struct packed {
    logic load;      // latch incoming word
    logic step;      // mix four bytes
    logic commit;    // event in order: update state
    logic set_err;   // first out-of-order event
    logic out_load;  // capture result word
  } eocf_cmd_t;

  typedef struct packed {
    logic sticky;    // error already flagged
    logic older;     // incoming timestamp below previous
  } eocf_sts_t;

  function automatic logic [63:0] fnv_byte(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b & BYTE_MASK};
    return (x << FNV_PRIME_SHIFT) + x * {55'd0, FNV_PRIME_LO};
  endfunction

  // little-endian: low byte first
  function automatic logic [63:0] fnv_word(input logic [63:0] h,
                                           input logic [WORD_W-1:0] w);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = fnv_byte(h, w[7:0]);
    b = fnv_byte(a, w[15:8]);
    c = fnv_byte(b, w[23:16]);
    return fnv_byte(c, w[31:24]);
  endfunction

endpackage

@@ sv/eocf_if.sv @@
`timescale 1ns / 1ps

interface eocf_in_if import eocf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [63:0] timestamp;
  logic        [31:0] instrument;
  logic        [63:0] order_ref;
  logic        [31:0] seq_number;

  modport source (output valid, timestamp, instrument, order_ref, seq_number,
                  input ready);
  modport sink   (input valid, timestamp, instrument, order_ref, seq_number,
                  output ready);
endinterface

interface eocf_out_if import eocf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic        [63:0] event_count;
  logic signed [63:0] first_time;
  logic signed [63:0] last_time;
  logic        [63:0] digest;
  logic               order_error;
  logic        [63:0] error_position;

  modport source (output valid, event_count, first_time, last_time, digest,
                  order_error, error_position, input ready);
  modport sink   (input valid, event_count, first_time, last_time, digest,
                  order_error, error_position, output ready);
endinterface

@@ sv/eocf_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eocf_ctrl import eocf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  eocf_sts_t sts,
  output eocf_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_DONE} state_t;
  typedef enum logic [1:0] {M_PASS, M_FAIL, M_HOLD} mode_t;

  localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(HASH_STEPS - 1);

  state_t                  state_r, state_nxt;
  mode_t                   mode_r, mode_nxt;
  logic [STEP_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    in_fire;
  logic                    done_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign in_fire   = in_valid && in_ready;
  // result register free, or being emptied this cycle
  assign done_go   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    cmd          = '0;
    cmd.load     = in_fire;
    cmd.step     = (state_r == S_HASH);
    cmd.commit   = done_go && (mode_r == M_PASS);
    cmd.set_err  = done_go && (mode_r == M_FAIL);
    cmd.out_load = done_go;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cnt_nxt = '0;
          if (sts.sticky) begin
            mode_nxt  = M_HOLD;
            state_nxt = S_DONE;
          end else if (sts.older) begin
            mode_nxt  = M_FAIL;
            state_nxt = S_DONE;
          end else begin
            mode_nxt  = M_PASS;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (done_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_PASS;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_NEXT(a_hash_after_pass, in_fire && !sts.sticky && !sts.older, state_r == S_HASH)
  `ASSERT_NEXT(a_last_step_done, state_r == S_HASH && cnt_r == STEP_LAST, state_r == S_DONE)
  `ASSERT_NEXT(a_done_shows_word, done_go, out_valid_r && state_r == S_IDLE)

endmodule

@@ sv/eocf_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eocf_dp import eocf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  eocf_cmd_t          cmd,
  output eocf_sts_t          sts,
  input  logic signed [63:0] in_timestamp,
  input  logic        [31:0] in_instrument,
  input  logic        [63:0] in_order_ref,
  input  logic        [31:0] in_seq_number,
  output logic        [63:0] out_event_count,
  output logic signed [63:0] out_first_time,
  output logic signed [63:0] out_last_time,
  output logic        [63:0] out_digest,
  output logic               out_order_error,
  output logic        [63:0] out_error_position
);

  // event state
  logic signed [63:0] prev_r, prev_nxt;
  logic        [63:0] count_r, count_nxt;
  logic signed [63:0] first_r, first_nxt;
  logic        [63:0] digest_r, digest_nxt;
  logic               sticky_r, sticky_nxt;
  logic        [63:0] eidx_r, eidx_nxt;
  // hash work
  logic [MSG_W-1:0]   msg_r, msg_nxt;
  logic [63:0]        hash_r, hash_nxt;
  // result word
  logic        [63:0] o_count_r;
  logic signed [63:0] o_first_r;
  logic signed [63:0] o_last_r;
  logic        [63:0] o_digest_r;
  logic               o_err_r;
  logic        [63:0] o_pos_r;
  logic signed [63:0] cur_ts;

  assign sts.sticky = sticky_r;
  assign sts.older  = (in_timestamp < prev_r);

  // message rotates a full turn during hashing, so timestamp is back in place
  assign cur_ts = $signed(msg_r[63:0]);

  always_comb begin
    msg_nxt  = msg_r;
    hash_nxt = hash_r;
    if (cmd.load) begin
      msg_nxt  = {32'd0, in_seq_number, in_order_ref, 32'd0, in_instrument,
                  in_timestamp};
      hash_nxt = digest_r;
    end else if (cmd.step) begin
      msg_nxt  = {msg_r[WORD_W-1:0], msg_r[MSG_W-1:WORD_W]};
      hash_nxt = fnv_word(hash_r, msg_r[WORD_W-1:0]);
    end
  end

  always_comb begin
    prev_nxt   = prev_r;
    count_nxt  = count_r;
    first_nxt  = first_r;
    digest_nxt = digest_r;
    sticky_nxt = sticky_r;
    eidx_nxt   = eidx_r;
    if (cmd.commit) begin
      if (count_r == 64'd0) begin
        first_nxt = cur_ts;
      end
      prev_nxt   = cur_ts;
      digest_nxt = hash_r;
      count_nxt  = count_r + 64'd1;
    end
    if (cmd.set_err) begin
      sticky_nxt = 1'b1;
      eidx_nxt   = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= TS_MIN;
      count_r  <= '0;
      first_r  <= '0;
      digest_r <= FNV_OFFSET;
      sticky_r <= 1'b0;
      eidx_r   <= '0;
    end else begin
      prev_r   <= prev_nxt;
      count_r  <= count_nxt;
      first_r  <= first_nxt;
      digest_r <= digest_nxt;
      sticky_r <= sticky_nxt;
      eidx_r   <= eidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r  <= msg_nxt;
    hash_r <= hash_nxt;
    if (cmd.out_load) begin
      o_count_r  <= count_nxt;
      o_first_r  <= first_nxt;
      o_last_r   <= (count_nxt == 64'd0) ? 64'sd0 : prev_nxt;
      o_digest_r <= digest_nxt;
      o_err_r    <= sticky_nxt;
      o_pos_r    <= sticky_nxt ? eidx_nxt : 64'd0;
    end
  end

  assign out_event_count    = o_count_r;
  assign out_first_time     = o_first_r;
  assign out_last_time      = o_last_r;
  assign out_digest         = o_digest_r;
  assign out_order_error    = o_err_r;
  assign out_error_position = o_pos_r;

  `ASSERT_NEXT(a_sticky_holds, sticky_r, sticky_r && $stable(eidx_r))
  `ASSERT_NEXT(a_frozen_after_err, sticky_r, $stable(count_r) && $stable(digest_r))
  `ASSERT_SAME(a_no_commit_on_err, cmd.commit, !sticky_r && !cmd.set_err)

endmodule

@@ sv/event_order_check_fingerprint.sv @@
`timescale 1ns / 1ps
// Event order checker with running 64-bit FNV-1a fingerprint.
// in_ch (valid/ready) takes one event word: timestamp, instrument, order_ref,
// seq_number. out_ch (valid/ready) returns exactly one result word per event:
// event count, first and last timestamp, digest, sticky order error and the
// index of the first out-of-order event.
// An in-order event is hashed as 32 little-endian bytes, four bytes per cycle
// through one chained FNV unit, then the result word is written; a new event
// is taken only after the result write of the previous one. An out-of-order
// event, or any event after the error flag is set, skips hashing and goes
// straight to the result write.
// The result sits in an output register; the next event is taken and hashed
// while it waits, and only the final write of that event waits for out_ch to
// drain. A stalled receiver therefore holds back at most one event.
// Synchronous active-low reset clears the count, error flag and first time,
// sets the digest to the FNV offset basis and the previous timestamp to the
// most negative value; no word is pending after reset.

module event_order_check_fingerprint import eocf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  eocf_in_if.sink    in_ch,
  eocf_out_if.source out_ch
);

  eocf_cmd_t cmd;
  eocf_sts_t sts;

  eocf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eocf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_timestamp       (in_ch.timestamp),
    .in_instrument      (in_ch.instrument),
    .in_order_ref       (in_ch.order_ref),
    .in_seq_number      (in_ch.seq_number),
    .out_event_count    (out_ch.event_count),
    .out_first_time     (out_ch.first_time),
    .out_last_time      (out_ch.last_time),
    .out_digest         (out_ch.digest),
    .out_order_error    (out_ch.order_error),
    .out_error_position (out_ch.error_position)
  );

endmodule

@@ dv/tb_event_order_check_fingerprint.sv @@
`timescale 1ns / 1ps

module tb_event_order_check_fingerprint import eocf_pkg::*;;

  localparam logic [63:0] FNV_PRIME64 = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] TS_MAX      = 64'h7fff_ffff_ffff_ffff;
  localparam int          RANDOM_EVENTS = 900;
  localparam int          QUIET_FROM    = 780;

  typedef struct packed {
    logic [63:0] event_count;
    logic [63:0] first_time;
    logic [63:0] last_time;
    logic [63:0] digest;
    logic        order_error;
    logic [63:0] error_position;
  } fp_result_t;

  logic clk;
  logic rst_n;

  eocf_in_if  in_if();
  eocf_out_if out_if();

  event_order_check_fingerprint DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // checker-side copy of the block state
  logic [63:0] prev_ts;
  logic [63:0] n_accepted;
  logic [63:0] first_stamp;
  logic [63:0] fp;
  logic        err_flag;
  logic [63:0] err_at;

  fp_result_t pending_results[$];
  int         fail_count;
  bit         no_idle;
  int         stall_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] fold_word(input logic [63:0] h, input logic [63:0] w);
    logic [63:0] acc;
    acc = h;
    for (int i = 0; i < 8; i++) begin
      acc = (acc ^ {56'd0, w[8*i +: 8]}) * FNV_PRIME64;
    end
    return acc;
  endfunction

  function automatic fp_result_t step_fingerprint(input logic [63:0] ts,
                                                  input logic [31:0] inst,
                                                  input logic [63:0] oref,
                                                  input logic [31:0] seq);
    fp_result_t r;
    if (!err_flag) begin
      if ($signed(ts) < $signed(prev_ts)) begin
        err_flag = 1'b1;
        err_at   = n_accepted;
      end else begin
        if (n_accepted == 64'd0) first_stamp = ts;
        prev_ts = ts;
        fp = fold_word(fp, ts);
        fp = fold_word(fp, {32'd0, inst});
        fp = fold_word(fp, oref);
        fp = fold_word(fp, {32'd0, seq});
        n_accepted = n_accepted + 64'd1;
      end
    end
    r.event_count    = n_accepted;
    r.first_time     = first_stamp;
    r.last_time      = (n_accepted == 64'd0) ? 64'd0 : prev_ts;
    r.digest         = fp;
    r.order_error    = err_flag;
    r.error_position = err_flag ? err_at : 64'd0;
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_event(input logic [63:0] ts, input logic [31:0] inst,
                            input logic [63:0] oref, input logic [31:0] seq);
    fp_result_t exp_word;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.timestamp  = ts;
    in_if.instrument = inst;
    in_if.order_ref  = oref;
    in_if.seq_number = seq;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    exp_word        = step_fingerprint(ts, inst, oref, seq);
    pending_results = {pending_results, exp_word};
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready = 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left   = $urandom_range(1, 8) - 1;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    fp_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: count %h digest %h",
               out_if.event_count, out_if.digest);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.event_count !== exp_r.event_count) begin
          $error("event_count: expected %h, got %h", exp_r.event_count, out_if.event_count);
          fail_count++;
        end
        if (out_if.first_time !== exp_r.first_time) begin
          $error("first_time: expected %h, got %h", exp_r.first_time, out_if.first_time);
          fail_count++;
        end
        if (out_if.last_time !== exp_r.last_time) begin
          $error("last_time: expected %h, got %h", exp_r.last_time, out_if.last_time);
          fail_count++;
        end
        if (out_if.digest !== exp_r.digest) begin
          $error("digest: expected %h, got %h", exp_r.digest, out_if.digest);
          fail_count++;
        end
        if (out_if.order_error !== exp_r.order_error) begin
          $error("order_error: expected %b, got %b", exp_r.order_error, out_if.order_error);
          fail_count++;
        end
        if (out_if.error_position !== exp_r.error_position) begin
          $error("error_position: expected %h, got %h",
                 exp_r.error_position, out_if.error_position);
          fail_count++;
        end
      end
    end
  end

  // field extremes, equal stamps, first event at the most negative stamp
  task automatic test_directed_extremes();
    send_event(TS_MIN, 32'h0, 64'h0, 32'h0);
    send_event(TS_MIN, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
    send_event(64'hffff_ffff_ffff_fffe, 32'haaaa_aaaa, 64'h5555_5555_5555_5555, 32'h5555_5555);
    send_event(64'hffff_ffff_ffff_ffff, 32'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 32'haaaa_aaaa);
    send_event(64'hffff_ffff_ffff_ffff, 32'h0000_0001, 64'h0000_0000_0000_0001, 32'h0000_0001);
    // crossing from negative to non-negative must stay in order
    send_event(64'h0, 32'h8000_0000, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_event(64'h0, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff);
    send_event(64'h1, 32'h0000_00ff, 64'h0000_0000_0000_00ff, 32'hff00_0000);
    send_event(64'd1000, $urandom, {$urandom, $urandom}, $urandom);
  endtask

  // hold the sender until the output side has caught up
  task automatic test_full_drain();
    repeat (4) send_event(prev_ts + $urandom_range(0, 3), $urandom,
                          {$urandom, $urandom}, $urandom);
    wait_drained();
  endtask

  // long nondecreasing run with a mix of equal, small and large steps
  task automatic test_random_ordered();
    logic [63:0] ts;
    logic [63:0] room;
    logic [63:0] jump;
    ts = prev_ts;
    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      if (i == QUIET_FROM) no_idle = 1'b1;
      room = TS_MAX - ts;
      case ($urandom_range(0, 9))
        0, 1, 2: jump = 64'd0;
        3, 4, 5, 6: jump = $urandom_range(1, 1000);
        default: jump = {$urandom, $urandom} % ((room >> 6) + 64'd1);
      endcase
      if (jump > room) jump = room;
      ts = ts + jump;
      send_event(ts, $urandom, {$urandom, $urandom}, $urandom);
    end
  endtask

  task automatic test_max_timestamp();
    send_event(TS_MAX, $urandom, {$urandom, $urandom}, $urandom);
    send_event(TS_MAX, $urandom, {$urandom, $urandom}, $urandom);
  endtask

  // -1 is above the max stamp when compared unsigned; must flag as backwards
  task automatic test_order_violation();
    send_event(64'hffff_ffff_ffff_ffff, $urandom, {$urandom, $urandom}, $urandom);
  endtask

  // state is frozen once the error is set
  task automatic test_after_error();
    send_event(TS_MAX, $urandom, {$urandom, $urandom}, $urandom);
    send_event(TS_MIN, $urandom, {$urandom, $urandom}, $urandom);
    for (int i = 0; i < 40; i++) begin
      send_event({$urandom, $urandom}, $urandom, {$urandom, $urandom}, $urandom);
    end
  endtask

  initial begin
    fail_count       = 0;
    no_idle          = 1'b0;
    stall_left       = 0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.timestamp  = '0;
    in_if.instrument = '0;
    in_if.order_ref  = '0;
    in_if.seq_number = '0;
    out_if.ready     = 1'b0;
    prev_ts          = TS_MIN;
    n_accepted       = 64'd0;
    first_stamp      = 64'd0;
    fp               = FNV_OFFSET;
    err_flag         = 1'b0;
    err_at           = 64'd0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_extremes();
    test_full_drain();
    test_random_ordered();
    test_max_timestamp();
    test_order_violation();
    test_after_error();

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
